/* hw/rtl/orrt_pkg.sv */
// Shared types and constants for the ordered range route table.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package orrt_pkg;

    localparam int unsigned KEY_W  = 16;
    localparam int unsigned PORT_W = 32;
    localparam int unsigned RCNT_W = 5;

    typedef enum logic [1:0] {
        KIND_APPEND = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_LOOKUP = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [PORT_W-1:0] port;
        logic [KEY_W-1:0]  high;
        logic [KEY_W-1:0]  low;
    } t_entry;

    // Packed with hit in bit 0 and removed_count in the top bits.
    typedef struct packed {
        logic [RCNT_W-1:0] removed_count;
        logic              table_full;
        logic [PORT_W-1:0] port_out;
        logic              hit;
    } t_result;

    typedef struct packed {
        logic load;
        logic scan;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

/* hw/rtl/orrt_ctrl.sv */
// Controller state machine for the ordered range route table.
// Depends on orrt_pkg; drives the datapath through t_cmd and reads t_status.
`default_nettype none

module orrt_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  orrt_pkg::t_kind     i_in_kind,
    output logic                o_in_ready,
    input  orrt_pkg::t_status   i_status,
    output orrt_pkg::t_cmd      o_cmd
);

    orrt_pkg::t_state r_state;
    orrt_pkg::t_state n_state;
    logic             in_xfer;
    logic             needs_scan;

    assign in_xfer    = i_in_valid && (r_state == orrt_pkg::ST_IDLE);
    assign needs_scan = (i_in_kind == orrt_pkg::KIND_REMOVE) ||
                        (i_in_kind == orrt_pkg::KIND_LOOKUP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= orrt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            orrt_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    n_state = needs_scan ? orrt_pkg::ST_SCAN : orrt_pkg::ST_DONE;
                end
            end
            orrt_pkg::ST_SCAN: begin
                if (i_status.scan_done) begin
                    n_state = orrt_pkg::ST_DONE;
                end
            end
            orrt_pkg::ST_DONE: begin
                if (i_status.out_free) begin
                    n_state = orrt_pkg::ST_IDLE;
                end
            end
            default: n_state = orrt_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            orrt_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = in_xfer;
            end
            orrt_pkg::ST_SCAN: begin
                o_cmd.scan = !i_status.scan_done;
            end
            orrt_pkg::ST_DONE: begin
                o_cmd.finish = i_status.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hw/rtl/orrt_dpath.sv */
// Datapath for the ordered range route table: entry memory, scan pointers,
// match and compaction logic, and the result register. Depends on orrt_pkg.
`default_nettype none

module orrt_dpath #(
    parameter int unsigned TABLE_DEPTH = 16
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  orrt_pkg::t_cmd                    i_cmd,
    output orrt_pkg::t_status                 o_status,
    input  orrt_pkg::t_kind                   i_in_kind,
    input  wire [orrt_pkg::KEY_W-1:0]         i_in_low,
    input  wire [orrt_pkg::KEY_W-1:0]         i_in_high,
    input  wire [orrt_pkg::PORT_W-1:0]        i_in_port,
    input  wire [orrt_pkg::KEY_W-1:0]         i_in_mtype,
    input  wire                               i_out_ready,
    output logic                              o_out_valid,
    output orrt_pkg::t_result                 o_out_data
);

    localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    orrt_pkg::t_entry mem [0:TABLE_DEPTH-1];

    orrt_pkg::t_kind              r_kind;
    logic [orrt_pkg::KEY_W-1:0]   r_low;
    logic [orrt_pkg::KEY_W-1:0]   r_high;
    logic [orrt_pkg::PORT_W-1:0]  r_port;
    logic [orrt_pkg::KEY_W-1:0]   r_mtype;

    logic [CNT_W-1:0]             r_count;
    logic [CNT_W-1:0]             r_idx;
    logic [CNT_W-1:0]             r_keep;
    logic                         r_rd_vld;
    orrt_pkg::t_entry             r_rd_data;
    logic                         r_hit;
    logic [orrt_pkg::PORT_W-1:0]  r_hit_port;
    logic                         r_out_valid;
    orrt_pkg::t_result            r_out;

    logic                         rd_en;
    logic                         wr_en;
    logic [IDX_W-1:0]             wr_addr;
    orrt_pkg::t_entry             wr_data;
    logic                         is_full;
    logic                         keep_it;
    logic                         match;
    logic [CNT_W-1:0]             diff;
    logic [CNT_W+orrt_pkg::RCNT_W-1:0] diff_ext;
    orrt_pkg::t_result            result;

    assign is_full  = (r_count == CNT_W'(TABLE_DEPTH));
    assign rd_en    = i_cmd.scan && (r_idx < r_count);
    assign keep_it  = (r_rd_data.port != r_port);
    assign match    = (r_rd_data.low <= r_mtype) && (r_mtype <= r_rd_data.high);
    assign diff     = r_count - r_keep;
    assign diff_ext = {{orrt_pkg::RCNT_W{1'b0}}, diff};

    // Compaction writes trail the read pointer, so a kept entry never
    // overwrites one that has not been read yet.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_count[IDX_W-1:0];
        wr_data = '{port: r_port, high: r_high, low: r_low};
        if (i_cmd.scan && r_rd_vld && (r_kind == orrt_pkg::KIND_REMOVE) && keep_it) begin
            wr_en   = 1'b1;
            wr_addr = r_keep[IDX_W-1:0];
            wr_data = r_rd_data;
        end else if (i_cmd.finish && (r_kind == orrt_pkg::KIND_APPEND) && !is_full) begin
            wr_en   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[r_idx[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= i_in_kind;
            r_low   <= i_in_low;
            r_high  <= i_in_high;
            r_port  <= i_in_port;
            r_mtype <= i_in_mtype;
        end
        if (i_cmd.scan && r_rd_vld && (r_kind == orrt_pkg::KIND_LOOKUP) && match && !r_hit) begin
            r_hit_port <= r_rd_data.port;
        end
        if (i_cmd.finish) begin
            r_out <= result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_idx       <= '0;
            r_keep      <= '0;
            r_rd_vld    <= 1'b0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_idx    <= '0;
                r_keep   <= '0;
                r_rd_vld <= 1'b0;
                r_hit    <= 1'b0;
            end else if (i_cmd.scan) begin
                r_rd_vld <= rd_en;
                if (rd_en) begin
                    r_idx <= r_idx + 1'b1;
                end
                if (r_rd_vld && (r_kind == orrt_pkg::KIND_REMOVE) && keep_it) begin
                    r_keep <= r_keep + 1'b1;
                end
                if (r_rd_vld && (r_kind == orrt_pkg::KIND_LOOKUP) && match) begin
                    r_hit <= 1'b1;
                end
            end
            if (i_cmd.finish) begin
                if ((r_kind == orrt_pkg::KIND_APPEND) && !is_full) begin
                    r_count <= r_count + 1'b1;
                end else if (r_kind == orrt_pkg::KIND_REMOVE) begin
                    r_count <= r_keep;
                end
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        result = '0;
        unique case (r_kind)
            orrt_pkg::KIND_APPEND: begin
                result.table_full = is_full;
            end
            orrt_pkg::KIND_REMOVE: begin
                result.removed_count = diff_ext[orrt_pkg::RCNT_W-1:0];
            end
            orrt_pkg::KIND_LOOKUP: begin
                result.hit      = r_hit;
                result.port_out = r_hit ? r_hit_port : '0;
            end
            orrt_pkg::KIND_NONE: begin
                result = '0;
            end
            default: result = '0;
        endcase
    end

    assign o_status.scan_done = r_hit || ((r_idx == r_count) && !r_rd_vld);
    assign o_status.out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid        = r_out_valid;
    assign o_out_data         = r_out;

endmodule

`default_nettype wire

/* hw/rtl/ordered_range_route_table.sv */
// Top level of the ordered range route table: stream ports, controller and
// datapath. Depends on orrt_pkg, orrt_ctrl and orrt_dpath.
//
//  Channel   Dir  Handshake                    Payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tuser: kind; tdata: low, high, port, msg type
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata: hit, port_out, table_full, removed_count
//
// An append does not scan the table. A remove or lookup reads the stored
// entries one entry per cycle through the single read port of the entry
// memory, with registered data; a lookup stops after its first match.
// Reset clears the entry count; entry contents stay undefined until written.
// A result waits in the output register while m_axis_tready is low; the next
// item is taken meanwhile, and its result is held until that register frees.
`default_nettype none

module ordered_range_route_table #(
    parameter int unsigned TABLE_DEPTH = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire [79:0]  s_axis_tdata,   // range_low[15:0], range_high[31:16],
                                        // port_id[63:32], mtype[79:64]
    input  wire [1:0]   s_axis_tuser,   // kind[1:0]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [39:0] m_axis_tdata    // hit[0], port_out[32:1], table_full[33],
                                        // removed_count[38:34], zero[39]
);

    orrt_pkg::t_cmd    cmd;
    orrt_pkg::t_status status;
    orrt_pkg::t_result out_data;
    orrt_pkg::t_kind   in_kind;

    assign in_kind = orrt_pkg::t_kind'(s_axis_tuser);

    orrt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_kind  (in_kind),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    orrt_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_kind   (in_kind),
        .i_in_low    (s_axis_tdata[15:0]),
        .i_in_high   (s_axis_tdata[31:16]),
        .i_in_port   (s_axis_tdata[63:32]),
        .i_in_mtype  (s_axis_tdata[79:64]),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (out_data)
    );

    assign m_axis_tdata = {1'b0, out_data};

    a_load_on_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |-> (s_axis_tvalid && s_axis_tready))
        else $error("item loaded without an input transfer");

    a_finish_shows_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.finish |=> m_axis_tvalid)
        else $error("finished item did not reach the output register");

    a_finish_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !cmd.finish)
        else $error("result register overwritten while stalled");

    a_one_command: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load, cmd.scan, cmd.finish}))
        else $error("more than one datapath command in a cycle");

endmodule

`default_nettype wire
